[hw/rtl/rsc_pkg.sv]
// rsc_pkg: shared types and constants of the rgb 5x5 sharpening filter
// used by rsc_front, rsc_queue, rsc_back and the top level rgb_sharpen_conv5x5
// no dependencies
package rsc_pkg;

  localparam int PIX_W = 24;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  // input word kinds carried on in_tuser
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd1;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam int QCW = 3;

  // pixel packed as blue [23:16], green [15:8], red [7:0]
  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic            push;   // shifts the tap window
    logic            emit;   // produces an output word
    logic            inner;  // filtered, else passed through
    logic            last;   // last output of the frame
    pix_t [3:0]      col;    // new window column, rows 0..3
    pix_t            pix;    // new window column, row 4
    pix_t            pass;   // stored pixel for pass-through
  } rsc_item_t;

  typedef struct packed {
    logic vld;
    logic inner;
    logic last;
    pix_t pass;
  } rsc_ctl_t;

endpackage

[hw/rtl/rsc_queue.sv]
// rsc_queue: short fifo of classified words between front and back
// depends on rsc_pkg
module rsc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  rsc_pkg::rsc_item_t  wr_item,
  input  logic                rd,
  output rsc_pkg::rsc_item_t  rd_item,
  output logic                empty,
  output logic [rsc_pkg::QCW-1:0] level
);

  rsc_pkg::rsc_item_t entry_r [rsc_pkg::QDEPTH];
  logic [rsc_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [rsc_pkg::QCW-1:0] level_r, level_nxt;

  always_ff @(posedge clk) begin
    if (wr) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  always_comb begin
    level_nxt = level_r;
    if (wr && !rd) begin
      level_nxt = level_r + rsc_pkg::QCW'(1);
    end else if (rd && !wr) begin
      level_nxt = level_r - rsc_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (wr) wr_ptr_r <= wr_ptr_r + rsc_pkg::QAW'(1);
      if (rd) rd_ptr_r <= rd_ptr_r + rsc_pkg::QAW'(1);
      level_r <= level_nxt;
    end
  end

  assign rd_item = entry_r[rd_ptr_r];
  assign empty   = (level_r == '0);
  assign level   = level_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> level_r != rsc_pkg::QCW'(rsc_pkg::QDEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> level_r != '0)
    else $error("queue read while empty");

  a_level_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> level_r == rsc_pkg::QCW'($past(level_r) + rsc_pkg::QCW'(1)))
    else $error("queue level lost a write");

endmodule

[hw/rtl/rsc_front.sv]
// rsc_front: accepts and classifies words, keeps the frame counters,
// the register file and the four row stores; depends on rsc_pkg
module rsc_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,
  input  logic                           in_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           restart,
  output logic                           q_wr,
  output rsc_pkg::rsc_item_t             q_item,
  input  logic [rsc_pkg::QCW-1:0]        q_level
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = $clog2(2 * MAX_WIDTH + 3);

  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [WW-1:0] eff_w;
  logic [15:0] eff_h;
  logic [LW-1:0] lag;

  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [15:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [LW-1:0] lag_cnt_r, lag_cnt_nxt;
  logic drain_r, drain_nxt;

  logic acc, do_push, do_drain, emit, inner, last, cfg_hit;
  logic [WW-1:0] in_col_p1, out_col_p1;
  logic [WW:0] out_col_p3;
  logic [16:0] in_row_p1, out_row_p3;
  rsc_pkg::pix_t pix;

  logic s1_vld_r, s1_push_r, s1_emit_r, s1_inner_r, s1_last_r;
  rsc_pkg::pix_t s1_pix_r;
  logic [1:0] s1_rbase_r, s1_pbank_r;
  rsc_pkg::pix_t rd_a_r [4];
  rsc_pkg::pix_t rd_b_r [4];

  // effective frame size
  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    eff_h = (height_r == '0) ? 16'd1 : height_r;
    lag   = LW'({eff_w, 1'b0}) + LW'(2);
  end

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == rsc_pkg::REG_WIDTH ||
                                   cfg_index == rsc_pkg::REG_HEIGHT);
  assign restart   = cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rsc_pkg::WIDTH_RST;
      height_r <= rsc_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == rsc_pkg::REG_WIDTH)  width_r  <= cfg_data[11:0];
      if (cfg_index == rsc_pkg::REG_HEIGHT) height_r <= cfg_data;
    end
  end

  // room for the word in flight plus this one
  assign in_tready = ((rsc_pkg::QCW + 1)'(q_level) + (rsc_pkg::QCW + 1)'(s1_vld_r))
                     < (rsc_pkg::QCW + 1)'(rsc_pkg::QDEPTH);
  assign acc      = in_tvalid && in_tready;
  assign do_push  = acc && (in_tuser == rsc_pkg::OP_PUSH) && !drain_r;
  assign do_drain = acc && (in_tuser == rsc_pkg::OP_DRAIN) && drain_r;
  assign emit     = do_drain || (do_push && lag_cnt_r == lag);
  assign pix      = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};

  assign in_col_p1  = WW'(in_col_r) + WW'(1);
  assign out_col_p1 = WW'(out_col_r) + WW'(1);
  assign out_col_p3 = (WW + 1)'(out_col_r) + (WW + 1)'(3);
  assign in_row_p1  = {1'b0, in_row_r} + 17'd1;
  assign out_row_p3 = {1'b0, out_row_r} + 17'd3;

  assign inner = do_push && out_row_r >= 16'd2 && out_row_p3 <= {1'b0, eff_h} &&
                 out_col_r >= CW'(2) && out_col_p3 <= (WW + 1)'(eff_w);
  assign last  = (out_row_r == eff_h - 16'd1) && (WW'(out_col_r) == eff_w - WW'(1));

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    lag_cnt_nxt = lag_cnt_r;
    drain_nxt   = drain_r;
    if (emit) begin
      if (last) begin
        out_col_nxt = '0;
        out_row_nxt = '0;
        drain_nxt   = 1'b0;
      end else if (out_col_p1 >= eff_w) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 16'd1;
      end else begin
        out_col_nxt = CW'(out_col_p1);
      end
    end
    if (do_push) begin
      if (lag_cnt_r != lag) lag_cnt_nxt = lag_cnt_r + LW'(1);
      if (in_col_p1 >= eff_w) begin
        in_col_nxt = '0;
        if (in_row_p1 >= {1'b0, eff_h}) begin
          in_row_nxt  = '0;
          drain_nxt   = 1'b1;
          lag_cnt_nxt = '0;
        end else begin
          in_row_nxt = in_row_p1[15:0];
        end
      end else begin
        in_col_nxt = CW'(in_col_p1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lag_cnt_r <= '0;
      drain_r   <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lag_cnt_r <= lag_cnt_nxt;
      drain_r   <= drain_nxt;
    end
  end

  // row stores: bank b holds the rows whose index is b modulo 4
  for (genvar b = 0; b < 4; b++) begin : g_bank
    rsc_pkg::pix_t bank_mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (do_push && in_row_r[1:0] == 2'(b)) begin
        bank_mem[in_col_r] <= pix;
      end
      rd_a_r[b] <= bank_mem[in_col_r];
      rd_b_r[b] <= bank_mem[out_col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= do_push || do_drain;
    end
  end

  always_ff @(posedge clk) begin
    s1_push_r  <= do_push;
    s1_emit_r  <= emit;
    s1_inner_r <= inner;
    s1_last_r  <= last;
    s1_pix_r   <= pix;
    s1_rbase_r <= in_row_r[1:0];
    s1_pbank_r <= out_row_r[1:0];
  end

  always_comb begin
    q_item.push  = s1_push_r;
    q_item.emit  = s1_emit_r;
    q_item.inner = s1_inner_r;
    q_item.last  = s1_last_r;
    q_item.pix   = s1_pix_r;
    q_item.pass  = rd_b_r[s1_pbank_r];
    for (int r = 0; r < 4; r++) begin
      q_item.col[r] = rd_a_r[2'(s1_rbase_r + 2'(r))];
    end
  end

  assign q_wr = s1_vld_r;

endmodule

[hw/rtl/rsc_back.sv]
// rsc_back: 5x5 tap window, kernel arithmetic and output register
// depends on rsc_pkg
module rsc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  logic               q_empty,
  input  rsc_pkg::rsc_item_t q_item,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,
  output logic               out_tlast
);

  logic en;
  rsc_pkg::pix_t win_r [5][5];
  rsc_pkg::rsc_ctl_t b1_r, b2_r, b3_r;
  logic out_vld_r, out_last_r;
  rsc_pkg::pix_t out_pix_r;

  logic [9:0]  g1_r [3], g6_r [3], g16_r [3], g24_r [3];
  logic [10:0] g4_r [3];
  logic [7:0]  ctr_r [3];
  logic [16:0] pos_r [3];
  logic [15:0] neg_r [3];
  rsc_pkg::pix_t res;

  assign en    = !out_vld_r || out_tready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 5; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (q_pop && q_item.push) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
      end
      for (int r = 0; r < 4; r++) begin
        win_r[r][4] <= q_item.col[r];
      end
      win_r[4][4] <= q_item.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r.vld  <= 1'b0;
      b2_r.vld  <= 1'b0;
      b3_r.vld  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      b1_r.vld  <= q_pop && q_item.emit;
      b2_r.vld  <= b1_r.vld;
      b3_r.vld  <= b2_r.vld;
      out_vld_r <= b3_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r.inner <= q_item.inner;
      b1_r.last  <= q_item.last;
      b1_r.pass  <= q_item.pass;
      {b2_r.inner, b2_r.last, b2_r.pass} <= {b1_r.inner, b1_r.last, b1_r.pass};
      {b3_r.inner, b3_r.last, b3_r.pass} <= {b2_r.inner, b2_r.last, b2_r.pass};
      out_last_r <= b3_r.last;
      out_pix_r  <= b3_r.inner ? res : b3_r.pass;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic signed [17:0] diff;
    logic [9:0] quo;

    // taps grouped by equal kernel weight
    always_ff @(posedge clk) begin
      if (en) begin
        g1_r[ch] <= 10'(win_r[0][0][8*ch +: 8]) + 10'(win_r[0][4][8*ch +: 8]) +
                    10'(win_r[4][0][8*ch +: 8]) + 10'(win_r[4][4][8*ch +: 8]);
        g4_r[ch] <= 11'(win_r[0][1][8*ch +: 8]) + 11'(win_r[0][3][8*ch +: 8]) +
                    11'(win_r[1][0][8*ch +: 8]) + 11'(win_r[1][4][8*ch +: 8]) +
                    11'(win_r[3][0][8*ch +: 8]) + 11'(win_r[3][4][8*ch +: 8]) +
                    11'(win_r[4][1][8*ch +: 8]) + 11'(win_r[4][3][8*ch +: 8]);
        g6_r[ch] <= 10'(win_r[0][2][8*ch +: 8]) + 10'(win_r[2][0][8*ch +: 8]) +
                    10'(win_r[2][4][8*ch +: 8]) + 10'(win_r[4][2][8*ch +: 8]);
        g16_r[ch] <= 10'(win_r[1][1][8*ch +: 8]) + 10'(win_r[1][3][8*ch +: 8]) +
                     10'(win_r[3][1][8*ch +: 8]) + 10'(win_r[3][3][8*ch +: 8]);
        g24_r[ch] <= 10'(win_r[1][2][8*ch +: 8]) + 10'(win_r[2][1][8*ch +: 8]) +
                     10'(win_r[2][3][8*ch +: 8]) + 10'(win_r[3][2][8*ch +: 8]);
        ctr_r[ch] <= win_r[2][2][8*ch +: 8];
        pos_r[ch] <= 17'(ctr_r[ch]) * 17'd476;
        neg_r[ch] <= 16'(g1_r[ch]) + 16'({g4_r[ch], 2'b00}) + 16'(g6_r[ch]) * 16'd6 +
                     16'({g16_r[ch], 4'b0000}) + 16'(g24_r[ch]) * 16'd24;
      end
    end

    // clamp at zero, scale by 1/256, saturate at 255
    always_comb begin
      diff = signed'({1'b0, pos_r[ch]}) - signed'({2'b00, neg_r[ch]});
      quo  = diff[17:8];
      if (diff < 0) begin
        res[8*ch +: 8] = 8'd0;
      end else if (quo > 10'd255) begin
        res[8*ch +: 8] = 8'd255;
      end else begin
        res[8*ch +: 8] = quo[7:0];
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_pix_r[7:0], out_pix_r[15:8], out_pix_r[23:16]};
  assign out_tlast  = out_last_r;

endmodule

[hw/rtl/rgb_sharpen_conv5x5.sv]
// rgb_sharpen_conv5x5: top level of the streaming 5x5 rgb sharpening filter
// depends on rsc_pkg, rsc_front, rsc_queue, rsc_back
//
// usage
//   in_*   : one word per pixel in raster order; in_tuser low pushes a pixel,
//            in_tuser high drains one pending output after the frame is in
//   out_*  : one word per result; out_tlast marks the last pixel of the frame
//   cfg_*  : register writes (width, height); each write restarts the frame
//            and is only issued while the filter is idle
//   each color is filtered with a fixed 5x5 kernel of gain 256 and clamped
//   to 0..255; the two-pixel border passes through unchanged
//   the result for pixel k comes with pushed pixel k + 2*width + 2, the rest
//   of the frame comes out with drain words
//   throughput: one word per clock while out_tready is high; a result shows on
//   out_tvalid after its input word is taken and has passed the row store read,
//   the queue, the window stage, two arithmetic stages and the output register
//   a stalled receiver holds the back end; the four-entry queue lets the
//   front keep taking words until it fills, then in_tready drops
//   reset: counters, window and queue clear, width 640, height 480;
//   row stores are not cleared
module rgb_sharpen_conv5x5 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // red, green, blue
  input  logic                           in_tuser,   // operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // red, green, blue
  output logic                           out_tlast,  // frame_end
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic restart, q_wr, q_rd, q_empty;
  logic [rsc_pkg::QCW-1:0] q_level;
  rsc_pkg::rsc_item_t q_wr_item, q_rd_item;

  // classification, counters and row stores
  rsc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .q_wr      (q_wr),
    .q_item    (q_wr_item),
    .q_level   (q_level)
  );

  // decouples the front from output stalls
  rsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (q_wr_item),
    .rd      (q_rd),
    .rd_item (q_rd_item),
    .empty   (q_empty),
    .level   (q_level)
  );

  // window, kernel and output register
  rsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (restart),
    .q_empty    (q_empty),
    .q_item     (q_rd_item),
    .q_pop      (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
